FILE: hw/rtl/mtt_pkg.sv
package mtt_pkg;

  localparam int unsigned MaxDim    = 1024;
  localparam int unsigned DimW      = 11;
  localparam int unsigned CountW    = 10;
  localparam int unsigned OffsetW   = 20;
  localparam int unsigned ValueW    = 32;
  localparam int unsigned InDataW   = 32;
  localparam int unsigned OutDataW  = 56;
  localparam int unsigned ProdW     = 21;

  typedef enum logic [1:0] {
    REG_TEX_WIDTH   = 2'd0,
    REG_TEX_HEIGHT  = 2'd1,
    REG_BGRA_ORDER  = 2'd2,
    REG_WIDE_FORMAT = 2'd3
  } cfg_index_t;

  // Settings as the datapath sees them, dimensions already clamped.
  typedef struct packed {
    logic [DimW-1:0] width;
    logic [DimW-1:0] height;
    logic            bgra;
    logic            wide;
  } mtt_cfg_t;

  // One pixel between the scan stage and the pack stage.
  typedef struct packed {
    logic [InDataW-1:0] bytes;
    logic [CountW-1:0]  col;
    logic [CountW-1:0]  out_row;
    logic               last;
  } pix_t;

  // Drops the low three bits and clamps the dimension to 8..MaxDim.
  function automatic logic [DimW-1:0] dim_effective(input logic [DimW-1:0] v);
    logic [DimW-1:0] t;
    t = {v[DimW-1:3], 3'b000};
    if (t == '0) begin
      t = DimW'(8);
    end else if (t > DimW'(MaxDim)) begin
      t = DimW'(MaxDim);
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/mtt_cfg_regs.sv
module mtt_cfg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  mtt_pkg::cfg_index_t          cfg_index,
  input  logic [mtt_pkg::DimW-1:0]     cfg_data,
  output mtt_pkg::mtt_cfg_t            cfg
);
  import mtt_pkg::*;

  logic [DimW-1:0] tex_width;
  logic [DimW-1:0] tex_height;
  logic            bgra_order;
  logic            wide_format;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width   <= DimW'(8);
      tex_height  <= DimW'(8);
      bgra_order  <= 1'b0;
      wide_format <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEX_WIDTH:   tex_width   <= cfg_data;
        REG_TEX_HEIGHT:  tex_height  <= cfg_data;
        REG_BGRA_ORDER:  bgra_order  <= cfg_data[0];
        REG_WIDE_FORMAT: wide_format <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg.width  = dim_effective(tex_width);
  assign cfg.height = dim_effective(tex_height);
  assign cfg.bgra   = bgra_order;
  assign cfg.wide   = wide_format;

endmodule

FILE: hw/rtl/mtt_scan.sv
module mtt_scan (
  input  logic                         clk,
  input  logic                         rst,
  input  mtt_pkg::mtt_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [mtt_pkg::InDataW-1:0]  in_data,
  output logic                         pix_valid,
  input  logic                         pix_ready,
  output mtt_pkg::pix_t                pix
);
  import mtt_pkg::*;

  logic [CountW-1:0] column_count;
  logic [CountW-1:0] row_count;
  logic [CountW-1:0] col_last;
  logic [CountW-1:0] row_last;
  logic [CountW-1:0] col_clamped;
  logic [CountW-1:0] row_clamped;
  logic              row_end;
  logic              frame_end;
  logic              take;

  assign col_last    = CountW'(cfg.width - DimW'(1));
  assign row_last    = CountW'(cfg.height - DimW'(1));
  assign col_clamped = (column_count < col_last) ? column_count : col_last;
  assign row_clamped = (row_count < row_last) ? row_count : row_last;
  assign row_end     = column_count >= col_last;
  assign frame_end   = row_end && (row_count >= row_last);

  assign in_ready = !pix_valid || pix_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid    <= 1'b0;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      if (in_ready) begin
        pix_valid <= in_valid;
      end
      if (take) begin
        priority if (frame_end) begin
          column_count <= '0;
          row_count    <= '0;
        end else if (row_end) begin
          column_count <= '0;
          row_count    <= row_count + CountW'(1);
        end else begin
          column_count <= column_count + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pix.bytes   <= in_data;
      pix.col     <= col_clamped;
      pix.out_row <= row_last - row_clamped;
      pix.last    <= frame_end;
    end
  end

endmodule

FILE: hw/rtl/mtt_pack.sv
module mtt_pack (
  input  logic                          clk,
  input  logic                          rst,
  input  mtt_pkg::mtt_cfg_t             cfg,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  mtt_pkg::pix_t                 pix,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mtt_pkg::OutDataW-1:0]  out_data,
  output logic                          out_last
);
  import mtt_pkg::*;

  logic [7:0]         red;
  logic [7:0]         green;
  logic [7:0]         blue;
  logic [7:0]         alpha;
  logic [ValueW-1:0]  value;
  logic [5:0]         morton;
  logic [ProdW-1:0]   row_base;
  logic [ProdW-1:0]   sum;
  logic               take;

  assign red   = cfg.bgra ? pix.bytes[23:16] : pix.bytes[7:0];
  assign green = pix.bytes[15:8];
  assign blue  = cfg.bgra ? pix.bytes[7:0] : pix.bytes[23:16];
  assign alpha = pix.bytes[31:24];

  assign value = cfg.wide ? {red, green, blue, alpha}
                          : {16'h0000, red[7:4], green[7:4], blue[7:4], alpha[7:4]};

  // Within a tile, column bits sit on the even positions and row bits on the odd ones.
  assign morton = {pix.out_row[2], pix.col[2], pix.out_row[1], pix.col[1],
                   pix.out_row[0], pix.col[0]};

  assign row_base = {ProdW'(pix.out_row[CountW-1:3]) * ProdW'(cfg.width)} << 3;
  assign sum      = row_base + ProdW'({pix.col[CountW-1:3], 6'b000000}) + ProdW'(morton);

  assign pix_ready = !out_valid || out_ready;
  assign take      = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_ready) begin
      out_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= {4'h0, value, sum[OffsetW-1:0]};
      out_last <= pix.last;
    end
  end

endmodule

FILE: hw/rtl/morton_texture_tiler_unit.sv
// Converts a stream of row-ordered pixels, bottom row first, into texels for an
// 8x8 Morton-tiled texture store, one pixel per clock while the output is not
// stalled. Each input word carries one pixel; each output word carries the
// texel's word offset and its packed value, and tlast marks the final pixel of
// the texture, after which the column and row counters start over. Each pixel
// passes through a scan stage that steps the counters and flips the row, then a
// pack stage with the one row-base multiply and the byte packing. Both stages
// hold a word while the output is stalled, so the block keeps taking pixels
// until both are full. Dimensions are rounded down to a multiple of eight and
// clamped to 8..1024. Configure only while no pixel is in flight.
module morton_texture_tiler_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // byte_zero, byte_one, byte_two, byte_three
  input  logic [mtt_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // texel_offset[19:0], texel_value[51:20], zero fill[55:52]
  output logic [mtt_pkg::OutDataW-1:0]  m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  mtt_pkg::cfg_index_t           cfg_index,
  input  logic [mtt_pkg::DimW-1:0]      cfg_data
);
  import mtt_pkg::*;

  mtt_cfg_t cfg;
  pix_t     pix;
  logic     pix_valid;
  logic     pix_ready;

  mtt_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mtt_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix)
  );

  mtt_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

FILE: hw/rtl/mtt_checker.sv
module mtt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mtt_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic                          m_axis_tlast
);
  import mtt_pkg::*;

  // Nothing is shown in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  // With no output word pending the pipeline must be free to take a pixel.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output is empty");

  // A stalled output word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output word changed");

  // The fill above the texel value stays zero.
  a_fill_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OutDataW-1:OffsetW+ValueW] == '0)
    else $error("output fill bits not zero");

endmodule

bind morton_texture_tiler_unit mtt_checker u_mtt_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

FILE: verif/tb_morton_texture_tiler_unit.sv
module tb_morton_texture_tiler_unit;
  import mtt_pkg::*;

  typedef struct packed {
    logic [OffsetW-1:0] offset;
    logic [ValueW-1:0]  value;
    logic               is_last;
  } texel_t;

  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ShownErrors = 10;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  cfg_index_t          cfg_index     = REG_TEX_WIDTH;
  logic [DimW-1:0]     cfg_data      = '0;

  logic [InDataW-1:0] pixel_queue[$];
  logic [InDataW-1:0] directed_px[$];
  texel_t             texel_queue[$];

  logic              in_taken    = 1'b0;
  int unsigned       src_idle    = 0;
  int unsigned       sink_idle   = 0;
  int unsigned       stall_cycles = 0;
  int unsigned       error_count = 0;

  // Mirror of the block's settings and scan position.
  logic [DimW-1:0]   width_reg;
  logic [DimW-1:0]   height_reg;
  logic              bgra_reg;
  logic              wide_reg;
  logic [CountW-1:0] col_cnt;
  logic [CountW-1:0] row_cnt;

  morton_texture_tiler_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned clamp_dim(input logic [DimW-1:0] v);
    int unsigned d;
    d = 32'({v[DimW-1:3], 3'b000});
    if (d < 8) begin
      d = 8;
    end else if (d > MaxDim) begin
      d = MaxDim;
    end
    return d;
  endfunction

  // Works out the tiled texel for one pixel and steps the scan position.
  function automatic texel_t tile_pixel(input logic [InDataW-1:0] px);
    texel_t      t;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int unsigned oy;
    logic [31:0] sum;
    logic        row_end;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    red   = bgra_reg ? px[23:16] : px[7:0];
    green = px[15:8];
    blue  = bgra_reg ? px[7:0] : px[23:16];
    alpha = px[31:24];
    x  = (32'(col_cnt) < w - 1) ? 32'(col_cnt) : w - 1;
    y  = (32'(row_cnt) < h - 1) ? 32'(row_cnt) : h - 1;
    oy = h - 1 - y;
    sum = {26'd0, oy[2], x[2], oy[1], x[1], oy[0], x[0]};
    sum = sum + (x & ~32'd7) * 8 + (oy & ~32'd7) * w;
    row_end = 32'(col_cnt) >= w - 1;
    t.offset  = sum[OffsetW-1:0];
    t.is_last = row_end && (32'(row_cnt) >= h - 1);
    if (wide_reg) begin
      t.value = {red, green, blue, alpha};
    end else begin
      t.value = {16'd0, red[7:4], green[7:4], blue[7:4], alpha[7:4]};
    end
    if (t.is_last) begin
      col_cnt = '0;
      row_cnt = '0;
    end else if (row_end) begin
      col_cnt = '0;
      row_cnt = row_cnt + CountW'(1);
    end else begin
      col_cnt = col_cnt + CountW'(1);
    end
    return t;
  endfunction

  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      if (!s_axis_tvalid || in_taken) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= src_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pixel_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= sink_idle);
    end
  end

  always @(posedge clk) begin : monitor
    texel_t want;
    texel_t got;
    if (rst) begin
      width_reg  = DimW'(8);
      height_reg = DimW'(8);
      bgra_reg   = 1'b0;
      wide_reg   = 1'b0;
      col_cnt    = '0;
      row_cnt    = '0;
      in_taken  <= 1'b0;
    end else begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEX_WIDTH:   width_reg  = cfg_data;
          REG_TEX_HEIGHT:  height_reg = cfg_data;
          REG_BGRA_ORDER:  bgra_reg   = cfg_data[0];
          REG_WIDE_FORMAT: wide_reg   = cfg_data[0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.offset  = m_axis_tdata[OffsetW-1:0];
        got.value   = m_axis_tdata[OffsetW+ValueW-1:OffsetW];
        got.is_last = m_axis_tlast;
        if (texel_queue.size() == 0) begin
          error_count++;
          if (error_count <= ShownErrors) begin
            $display("unexpected texel word: offset %h value %h last %b",
                     got.offset, got.value, got.is_last);
          end
        end else begin
          want = texel_queue.pop_front();
          if (got.offset !== want.offset || got.value !== want.value ||
              got.is_last !== want.is_last) begin
            error_count++;
            if (error_count <= ShownErrors) begin
              $display("texel mismatch: expected offset %h value %h last %b, got offset %h value %h last %b",
                       want.offset, want.value, want.is_last,
                       got.offset, got.value, got.is_last);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        texel_queue.push_back(tile_pixel(s_axis_tdata));
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic drain();
    @(posedge clk);
    while (pixel_queue.size() != 0 || s_axis_tvalid || texel_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_index_t idx, input logic [DimW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned w, input int unsigned h,
                           input int unsigned bgra, input int unsigned wide,
                           input int unsigned n,
                           input int unsigned src_pct, input int unsigned sink_pct);
    drain();
    cfg_write(REG_TEX_WIDTH, DimW'(w));
    cfg_write(REG_TEX_HEIGHT, DimW'(h));
    cfg_write(REG_BGRA_ORDER, {(DimW-1)'($urandom_range(0, 1023)), bgra[0]});
    cfg_write(REG_WIDE_FORMAT, {(DimW-1)'($urandom_range(0, 1023)), wide[0]});
    src_idle  = src_pct;
    sink_idle = sink_pct;
    foreach (directed_px[i]) pixel_queue.push_back(directed_px[i]);
    directed_px.delete();
    repeat (n) pixel_queue.push_back($urandom());
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic int unsigned pick_dim();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 2047);
      1:       return MaxDim;
      default: return 8 * $urandom_range(1, 3) +
                      (($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0);
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_px = '{32'h0000_0000, 32'hffff_ffff, 32'h0f1e_2d3c, 32'hf0e1_d2c3};
    run_phase(8, 8, 0, 0, 0, 32, 56);
    directed_px = '{32'h0000_0000, 32'hffff_ffff, 32'h1122_3344, 32'h8040_2010};
    run_phase(8, 8, 1, 1, 0, 32, 56);
    run_phase(1024, 1024, 0, 1, 3, 32, 56);
    run_phase(0, 2047, 1, 0, 3, 32, 56);
    run_phase(13, 7, 0, 1, 8, 32, 56);

    run_phase(8, 8, 0, 0, 100, 32, 56);
    run_phase(1024, 8, 1, 0, 40, 32, 56);
    run_phase(16, 8, 0, 1, 100, 32, 56);
    run_phase(8, 1024, 1, 1, 96, 32, 56);
    run_phase(8, 8, 0, 0, 80, 32, 56);
    run_phase(2047, 0, 1, 0, 60, 32, 56);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 1) begin
        run_phase(pick_dim(), pick_dim(), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(50, 130), 32, 56);
      end else if (ph < 6) begin
        run_phase(pick_dim(), pick_dim(), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(50, 130), 56, 32);
      end else begin
        run_phase(pick_dim(), pick_dim(), $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(50, 130), 0, 0);
      end
    end

    drain();
    if (error_count == 0 && texel_queue.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
